[design/lfp_pkg.sv]
package lfp_pkg;

	// Field and datapath widths fixed by the block's interface
	localparam int GAIN_W       = 16;
	localparam int SPIN_W       = 14;
	localparam int INTEG_W      = 32;
	localparam int PROD_W       = GAIN_W + 1 + INTEG_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int DRIVE_W      = 16;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 16;
	localparam int QUEUE_DEPTH  = 2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_KP_GAIN      = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KI_GAIN      = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KD_GAIN      = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_DRIVE = 4'd3;

	// Sensor position weights in tenths, from the centre outward
	localparam int WEIGHT_TENTHS [8] = '{2, 8, 18, 34, 50, 66, 82, 98};

	// Classification of one reading, handed from front to back
	typedef struct packed {
		logic none_seen;
		logic turn_neg;
		logic turn_pos;
	} lfp_flags_t;

	localparam int FLAGS_W = $bits(lfp_flags_t);

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [SPIN_W-1:0] search_drive;
	} lfp_gains_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_NEG,
		DIR_POS
	} lfp_dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC,
		ST_CLAMP
	} lfp_state_t;

endpackage

[design/line_follow_pid_controller.sv]
// Line-following PID controller. Each reading of the line sensors (bit clear = line seen)
// gives one pair of motor drives in signed fixed point with FRACTION_BITS fraction bits,
// or none for the first seeing reading after the line was lost. A three-stage front
// weighs the sensors and divides by the count with a reciprocal multiply; a two-entry
// queue then feeds the back, which steps one 17x32 multiplier through the P, I and D
// terms. A tracking reading holds the back until the clamp state loads the output, which
// waits on a stalled output; lost-line and search-exit readings are taken from idle.
// Gains are written through the configuration channel, which is always ready; the user
// must write them only while no reading is in flight, as the block does not enforce it.
module line_follow_pid_controller
	import lfp_pkg::*;
#(
	parameter int SENSOR_COUNT  = 8,
	parameter int FRACTION_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                sensor_bits,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] left_drive,
	output logic signed [DRIVE_W-1:0] right_drive,
	output logic                      line_lost,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int ERR_W   = FRACTION_BITS + 5;
	localparam int ENTRY_W = FLAGS_W + ERR_W;
	localparam logic [31:0] KP_RESET = (32'd3 << FRACTION_BITS) >> 1;
	localparam logic [31:0] KD_RESET = 32'd2 << FRACTION_BITS;

	lfp_gains_t              gains_q;
	logic                    f_valid, f_ready;
	lfp_flags_t              f_flags;
	logic signed [ERR_W-1:0] f_error;
	logic                    b_valid, b_ready;
	logic [ENTRY_W-1:0]      q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	// Gain and spin registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp           <= KP_RESET[GAIN_W-1:0];
			gains_q.ki           <= '0;
			gains_q.kd           <= KD_RESET[GAIN_W-1:0];
			gains_q.search_drive <= 14'd8192;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KP_GAIN:      gains_q.kp           <= cfg_data;
				CFG_KI_GAIN:      gains_q.ki           <= cfg_data;
				CFG_KD_GAIN:      gains_q.kd           <= cfg_data;
				CFG_SEARCH_DRIVE: gains_q.search_drive <= cfg_data[SPIN_W-1:0];
				default:          gains_q              <= gains_q;
			endcase
		end
	end

	lfp_front #(
		.SENSOR_COUNT  (SENSOR_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sensor_bits (sensor_bits),
		.push_valid  (f_valid),
		.push_ready  (f_ready),
		.push_flags  (f_flags),
		.push_error  (f_error)
	);

	assign q_wdata = {f_flags, f_error};

	lfp_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_wdata),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_rdata)
	);

	lfp_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (b_valid),
		.pop_ready   (b_ready),
		.head_flags  (lfp_flags_t'(q_rdata[ERR_W +: FLAGS_W])),
		.head_error  ($signed(q_rdata[ERR_W-1:0])),
		.gains       (gains_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.line_lost   (line_lost)
	);

endmodule

[design/lfp_front.sv]
module lfp_front
	import lfp_pkg::*;
#(
	parameter int SENSOR_COUNT  = 8,
	parameter int FRACTION_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      sensor_bits,
	output logic                            push_valid,
	input  logic                            push_ready,
	output lfp_flags_t                      push_flags,
	output logic signed [FRACTION_BITS+4:0] push_error
);

	localparam int ERR_W = FRACTION_BITS + 5;
	localparam int SUM_W = FRACTION_BITS + 7;
	localparam int MAG_W = SUM_W - 1;
	localparam int RCP_W = MAG_W + 1;
	localparam int MP_W  = MAG_W + RCP_W;
	localparam int REM_W = MAG_W + 4;
	localparam int CNT_W = 4;
	localparam int OUTER_HI = SENSOR_COUNT - 1;

	// Reciprocals of each count of seeing sensors, scaled by two to the magnitude width
	localparam longint unsigned RCP_BASE = 64'd1 << MAG_W;
	localparam longint unsigned RCP_2 = RCP_BASE / 2;
	localparam longint unsigned RCP_3 = RCP_BASE / 3;
	localparam longint unsigned RCP_4 = RCP_BASE / 4;
	localparam longint unsigned RCP_5 = RCP_BASE / 5;
	localparam longint unsigned RCP_6 = RCP_BASE / 6;
	localparam longint unsigned RCP_7 = RCP_BASE / 7;
	localparam longint unsigned RCP_8 = RCP_BASE / 8;

	function automatic int weight_fx(int idx);
		int half;
		int span;
		half = SENSOR_COUNT / 2;
		weight_fx = 0;
		if (idx < half) begin
			span = half - 1 - idx;
			weight_fx = (WEIGHT_TENTHS[span & 7] * (1 << FRACTION_BITS) + 5) / 10;
		end else if (idx >= SENSOR_COUNT - half) begin
			span = idx - (SENSOR_COUNT - half);
			weight_fx = -((WEIGHT_TENTHS[span & 7] * (1 << FRACTION_BITS) + 5) / 10);
		end
	endfunction

	logic                    adv;
	logic [7:0]              seen;
	logic signed [SUM_W-1:0] term [8];
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_abs;
	logic [CNT_W-1:0]        cnt;
	logic                    turn_pos;
	lfp_flags_t              flags;

	logic                    v_s1, v_s2, v_s3;
	logic [MAG_W-1:0]        mag_s1, mag_s2;
	logic                    neg_s1, neg_s2;
	logic [CNT_W-1:0]        cnt_s1, cnt_s2;
	lfp_flags_t              flags_s1, flags_s2, flags_s3;
	logic [MAG_W-1:0]        quo_s2;
	logic signed [ERR_W-1:0] err_s3;

	logic [RCP_W-1:0]        rcp;
	logic [MP_W-1:0]         rcp_prod;
	logic [REM_W-1:0]        rem;
	logic [MAG_W-1:0]        quo;
	logic [ERR_W-1:0]        quo_mag;

	// Whole pipe moves together; it stalls only when the queue refuses a transfer
	assign adv        = !v_s3 || push_ready;
	assign in_ready   = adv;
	assign push_valid = v_s3;
	assign push_flags = flags_s3;
	assign push_error = err_s3;

	// Map each sensor to its seen bit and its weighted term
	for (genvar g = 0; g < 8; g++) begin : g_sensor
		localparam int WEIGHT = weight_fx(g);
		if (g < SENSOR_COUNT) begin : g_used
			assign seen[g] = ~sensor_bits[g];
		end else begin : g_unused
			assign seen[g] = 1'b0;
		end
		assign term[g] = seen[g] ? SUM_W'(WEIGHT) : '0;
	end

	// Outer pair on the high side
	if (OUTER_HI < 8) begin : g_outer
		assign turn_pos = seen[OUTER_HI] & seen[OUTER_HI-1];
	end else begin : g_no_outer
		assign turn_pos = 1'b0;
	end

	// Sum the weights and count the seeing sensors
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + term[i];
			cnt = cnt + CNT_W'(seen[i]);
		end
	end

	assign sum_abs         = sum[SUM_W-1] ? -sum : sum;
	assign flags.none_seen = (cnt == '0);
	assign flags.turn_neg  = seen[0] & seen[1];
	assign flags.turn_pos  = turn_pos;

	// Pick the reciprocal of the count
	always_comb begin
		case (cnt_s1)
			4'd1:    rcp = RCP_BASE[RCP_W-1:0];
			4'd2:    rcp = RCP_2[RCP_W-1:0];
			4'd3:    rcp = RCP_3[RCP_W-1:0];
			4'd4:    rcp = RCP_4[RCP_W-1:0];
			4'd5:    rcp = RCP_5[RCP_W-1:0];
			4'd6:    rcp = RCP_6[RCP_W-1:0];
			4'd7:    rcp = RCP_7[RCP_W-1:0];
			4'd8:    rcp = RCP_8[RCP_W-1:0];
			default: rcp = '0;
		endcase
	end

	assign rcp_prod = MP_W'(mag_s1) * MP_W'(rcp);

	// Estimate is low by at most one; correct it from the remainder
	assign rem     = REM_W'(mag_s2) - REM_W'(quo_s2) * REM_W'(cnt_s2);
	assign quo     = quo_s2 + MAG_W'(rem >= REM_W'(cnt_s2));
	assign quo_mag = {1'b0, quo[ERR_W-2:0]};

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1   <= sum_abs[MAG_W-1:0];
			neg_s1   <= sum[SUM_W-1];
			cnt_s1   <= cnt;
			flags_s1 <= flags;
			mag_s2   <= mag_s1;
			neg_s2   <= neg_s1;
			cnt_s2   <= cnt_s1;
			flags_s2 <= flags_s1;
			quo_s2   <= rcp_prod[2*MAG_W-1:MAG_W];
			flags_s3 <= flags_s2;
			err_s3   <= neg_s2 ? -$signed(quo_mag) : $signed(quo_mag);
		end
	end

endmodule

[design/lfp_queue.sv]
module lfp_queue
	import lfp_pkg::*;
#(
	parameter int WIDTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	logic             push, pop;

	assign push_ready = (fill_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[design/lfp_back.sv]
module lfp_back
	import lfp_pkg::*;
#(
	parameter int FRACTION_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  lfp_flags_t                      head_flags,
	input  logic signed [FRACTION_BITS+4:0] head_error,
	input  lfp_gains_t                      gains,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [DRIVE_W-1:0]       left_drive,
	output logic signed [DRIVE_W-1:0]       right_drive,
	output logic                            line_lost
);

	localparam int ERR_W = FRACTION_BITS + 5;
	localparam logic signed [ACC_W:0] ONE_W =
		{{(ACC_W-FRACTION_BITS){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

	lfp_state_t                state_q, state_d;
	lfp_dir_t                  dir_q;
	logic                      searching_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W:0]     deriv_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] left_q, right_q;
	logic                      lost_q;

	logic                      out_free;
	logic                      load_out;
	logic                      pop;
	logic signed [GAIN_W:0]    mul_a;
	logic signed [INTEG_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_next;
	logic [DRIVE_W-1:0]        spin_mag;
	logic signed [DRIVE_W-1:0] spin_left;
	logic signed [ACC_W-1:0]   diff;
	logic signed [ACC_W:0]     left_raw, right_raw;
	logic signed [ACC_W:0]     left_clamped, right_clamped;

	assign out_free    = !out_valid_q || out_ready;
	assign pop         = pop_valid && pop_ready;
	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign line_lost   = lost_q;

	// Saturating integral update
	assign integ_sum  = {integ_q[INTEG_W-1], integ_q}
		+ {{(INTEG_W+1-ERR_W){head_error[ERR_W-1]}}, head_error};
	assign integ_next = (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
		? (integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}})
		: integ_sum[INTEG_W-1:0];

	// Spin command while the line is lost
	assign spin_mag = {1'b0, gains.search_drive, 1'b0};
	always_comb begin
		case (dir_q)
			DIR_NEG: spin_left = -$signed(spin_mag);
			DIR_POS: spin_left = $signed(spin_mag);
			default: spin_left = '0;
		endcase
	end

	// Scale down and clamp the PID sum into the two drives
	assign diff      = acc_q >>> FRACTION_BITS;
	assign left_raw  = ONE_W - {diff[ACC_W-1], diff};
	assign right_raw = ONE_W + {diff[ACC_W-1], diff};
	always_comb begin
		if (left_raw > ONE_W) begin
			left_clamped = ONE_W;
		end else if (left_raw < -ONE_W) begin
			left_clamped = -ONE_W;
		end else begin
			left_clamped = left_raw;
		end
		if (right_raw > ONE_W) begin
			right_clamped = ONE_W;
		end else if (right_raw < -ONE_W) begin
			right_clamped = -ONE_W;
		end else begin
			right_clamped = right_raw;
		end
	end

	// Shared gain multiplier
	assign prod = mul_a * mul_b;

	// Next state, queue pop, output load and multiplier operands
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load_out  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					if (head_flags.none_seen) begin
						if (out_free) begin
							pop_ready = 1'b1;
							load_out  = 1'b1;
						end
					end else begin
						pop_ready = 1'b1;
						if (!searching_q) begin
							state_d = ST_MUL_P;
						end
					end
				end
			end
			ST_MUL_P: begin
				mul_a   = {1'b0, gains.kp};
				mul_b   = {{(INTEG_W-ERR_W){prev_q[ERR_W-1]}}, prev_q};
				state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				mul_a   = {1'b0, gains.ki};
				mul_b   = integ_q;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				mul_a   = {1'b0, gains.kd};
				mul_b   = {{(INTEG_W-ERR_W-1){deriv_q[ERR_W]}}, deriv_q};
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Controller state: search flag, turn direction, last error, integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
			dir_q       <= DIR_NONE;
			prev_q      <= '0;
			integ_q     <= '0;
		end else if (pop) begin
			if (head_flags.none_seen) begin
				searching_q <= 1'b1;
			end else if (searching_q) begin
				searching_q <= 1'b0;
			end else begin
				prev_q  <= head_error;
				integ_q <= integ_next;
				if (head_flags.turn_pos) begin
					dir_q <= DIR_POS;
				end else if (head_flags.turn_neg) begin
					dir_q <= DIR_NEG;
				end
			end
		end
	end

	// Derivative, product and accumulator
	always_ff @(posedge clk) begin
		if (pop && state_q == ST_IDLE) begin
			deriv_q <= {head_error[ERR_W-1], head_error} - {prev_q[ERR_W-1], prev_q};
		end
		prod_q <= prod;
		case (state_q)
			ST_MUL_I:        acc_q <= ACC_W'(prod_q);
			ST_MUL_D, ST_ACC: acc_q <= acc_q + ACC_W'(prod_q);
			default:         acc_q <= acc_q;
		endcase
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_CLAMP) begin
				left_q  <= left_clamped[DRIVE_W-1:0];
				right_q <= right_clamped[DRIVE_W-1:0];
				lost_q  <= 1'b0;
			end else begin
				left_q  <= spin_left;
				right_q <= -spin_left;
				lost_q  <= 1'b1;
			end
		end
	end

endmodule

[design/lfp_checker.sv]
module lfp_checker #(
	parameter int FRACTION_BITS = 12
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [15:0] left_drive,
	input logic signed [15:0] right_drive,
	input logic              line_lost
);

	localparam bit RANGE_CHECKED = (FRACTION_BITS <= 14);
	localparam logic signed [15:0] ONE_DRIVE = 16'(1 << FRACTION_BITS);

	// Hold a refused result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive)
			&& $stable(right_drive) && $stable(line_lost))
		else $error("result changed while stalled");

	// Spin commands turn the wheels in opposite directions
	a_spin_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_lost |-> right_drive == -left_drive)
		else $error("spin drives not mirrored");

	// Spin magnitude is twice the spin register
	a_spin_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_lost |-> !left_drive[0])
		else $error("spin drive is odd");

	// Tracking drives stay within plus or minus full forward when FRACTION_BITS is at most 14
	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_lost |-> !RANGE_CHECKED
			|| (left_drive <= ONE_DRIVE && left_drive >= -ONE_DRIVE
			&& right_drive <= ONE_DRIVE && right_drive >= -ONE_DRIVE))
		else $error("tracking drive out of range");

endmodule

bind line_follow_pid_controller lfp_checker #(
	.FRACTION_BITS (FRACTION_BITS)
) u_lfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.line_lost   (line_lost)
);
